// ===== rtl/core/glbw_pkg.sv =====
// Shared constants and types for the grid line block walker.
package glbw_pkg;

  localparam int CELL_SHIFT = 23;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_CELLS  = 64;

  localparam int WORD_W     = 32;
  localparam int SUB_SHIFT  = CELL_SHIFT - FRAC_BITS;
  localparam int PART_W     = FRAC_BITS + 1;
  localparam int CI_W       = WORD_W - CELL_SHIFT;
  localparam int CNT_W      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int COL_W      = CI_W + CNT_W + 1;
  localparam int CELL_OUT_W = 9;
  localparam int SAT_SHIFT  = 30 - FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(WORD_W);

  localparam int IN_TDATA_W  = 4 * WORD_W;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 1'b1;

  localparam logic [WORD_W-1:0] ONE_FIX    = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FLAT_SLOPE = WORD_W'(256) << FRAC_BITS;
  localparam logic [WORD_W-1:0] SAT_POS    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_NEG    = {1'b1, {(WORD_W-1){1'b0}}};

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] num;
    logic [WORD_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
    mag32 = v[WORD_W-1] ? (WORD_W'(0) - v) : v;
  endfunction

endpackage

// ===== rtl/core/glbw_div.sv =====
// Bit-serial saturating 16.16 fixed-point divider.
module glbw_div (
  input  logic                clk,
  input  logic                rst,
  input  glbw_pkg::div_req_t  req,
  output glbw_pkg::div_rsp_t  rsp
);
  import glbw_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_FIN  = 3'b100
  } div_state_t;

  div_state_t           state;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    shf;
  logic [WORD_W-1:0]    den;
  logic [WORD_W-1:0]    quo;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;

  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;
  logic              sat;
  logic [WORD_W:0]   trial;
  logic              take;

  always_comb begin
    mag_a = mag32(req.num);
    mag_b = mag32(req.den);
    sat   = (mag_a >> SAT_SHIFT) >= mag_b;
    trial = {rem, shf[WORD_W-1]};
    take  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        DV_IDLE: begin
          if (req.start) begin
            if (sat) begin
              quo   <= (req.num[WORD_W-1] ^ req.den[WORD_W-1]) ? SAT_NEG : SAT_POS;
              neg   <= 1'b0;
              state <= DV_FIN;
            end else begin
              rem   <= WORD_W'(mag_a >> FRAC_BITS);
              shf   <= mag_a << FRAC_BITS;
              den   <= mag_b;
              quo   <= '0;
              neg   <= req.num[WORD_W-1] ^ req.den[WORD_W-1];
              cnt   <= '0;
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          rem <= take ? WORD_W'(trial - {1'b0, den}) : trial[WORD_W-1:0];
          shf <= shf << 1;
          quo <= {quo[WORD_W-2:0], take};
          cnt <= cnt + 1'b1;
          if (cnt == DIV_CNT_W'(WORD_W - 1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          state <= DV_IDLE;
        end
        default: begin
          state <= DV_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = (state == DV_FIN);
    rsp.quot = neg ? (WORD_W'(0) - quo) : quo;
  end

endmodule

// ===== rtl/core/grid_line_block_walker.sv =====
// Top level of the grid line block walker: sequencer, setup datapath and cell stepper.
// One segment transaction on the slave side yields between 1 and 64 cell transactions on the
// master side, the last one carrying tlast. The block takes a segment only when it is idle.
// Most of the setup after a segment is taken is the shared bit-serial divider, which runs
// once per axis that changes column or row and holds the sequencer until it is done
// (the division is skipped when the slope saturates); a shared multiplier and adder then
// place the first intercepts. The walk then gives one cell per cycle while the master side
// takes them.
// The next segment is taken in the cycle after the last cell is loaded into the output register.
module grid_line_block_walker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [glbw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [glbw_pkg::WORD_W-1:0]          cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // start_x [31:0], start_y [63:32], end_x [95:64], end_y [127:96]
  input  logic [glbw_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // cell_x [8:0], cell_y [17:9], zero fill [23:18]
  output logic [glbw_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast,
  // reached_end [0]
  output logic                                 m_tuser
);
  import glbw_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_ADJ   = 10'b0000000010,
    ST_SETUP = 10'b0000000100,
    ST_WAITY = 10'b0000001000,
    ST_MULY  = 10'b0000010000,
    ST_ADDY  = 10'b0000100000,
    ST_WAITX = 10'b0001000000,
    ST_MULX  = 10'b0010000000,
    ST_ADDX  = 10'b0100000000,
    ST_WALK  = 10'b1000000000
  } state_t;

  state_t            state;
  logic [WORD_W-1:0] origin_x;
  logic [WORD_W-1:0] origin_y;
  logic [WORD_W-1:0] x1;
  logic [WORD_W-1:0] y1;
  logic [WORD_W-1:0] x2;
  logic [WORD_W-1:0] y2;
  logic [CI_W-1:0]   cx2;
  logic [CI_W-1:0]   cy2;
  logic              xup;
  logic              xdn;
  logic              yup;
  logic              ydn;
  logic [PART_W-1:0] part_x;
  logic [PART_W-1:0] part_y;
  logic [WORD_W-1:0] xslope;
  logic [WORD_W-1:0] yslope;
  logic [WORD_W-1:0] xcross;
  logic [WORD_W-1:0] ycross;
  logic [WORD_W-1:0] prod;
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  row;
  logic [CNT_W-1:0]  cnt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [CI_W-1:0]            cx1_c;
  logic [CI_W-1:0]            cy1_c;
  logic [CI_W-1:0]            cx2_c;
  logic [CI_W-1:0]            cy2_c;
  logic [WORD_W-1:0]          xs1;
  logic [WORD_W-1:0]          ys1;
  logic [PART_W-1:0]          part_x_c;
  logic [PART_W-1:0]          part_y_c;
  logic                       xup_c;
  logic                       xdn_c;
  logic                       yup_c;
  logic                       ydn_c;
  logic [PART_W-1:0]          mul_a;
  logic [WORD_W-1:0]          mul_b;
  logic [PART_W+WORD_W-1:0]   mul_p;
  logic [WORD_W-1:0]          row_w;
  logic [WORD_W-1:0]          col_w;
  logic [WORD_W-1:0]          ycell;
  logic [WORD_W-1:0]          xcell;
  logic                       hit;
  logic                       at_limit;
  logic                       emit;
  logic                       emit_last;

  glbw_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    cx1_c = x1[WORD_W-1:CELL_SHIFT];
    cy1_c = y1[WORD_W-1:CELL_SHIFT];
    cx2_c = x2[WORD_W-1:CELL_SHIFT];
    cy2_c = y2[WORD_W-1:CELL_SHIFT];
    xs1   = WORD_W'($signed(x1) >>> SUB_SHIFT);
    ys1   = WORD_W'($signed(y1) >>> SUB_SHIFT);
    xup_c = $signed(cx2_c) > $signed(cx1_c);
    xdn_c = $signed(cx2_c) < $signed(cx1_c);
    yup_c = $signed(cy2_c) > $signed(cy1_c);
    ydn_c = $signed(cy2_c) < $signed(cy1_c);

    if (xup_c) begin
      part_x_c = PART_W'(ONE_FIX) - {1'b0, xs1[FRAC_BITS-1:0]};
    end else if (xdn_c) begin
      part_x_c = {1'b0, xs1[FRAC_BITS-1:0]};
    end else begin
      part_x_c = PART_W'(ONE_FIX);
    end
    if (yup_c) begin
      part_y_c = PART_W'(ONE_FIX) - {1'b0, ys1[FRAC_BITS-1:0]};
    end else if (ydn_c) begin
      part_y_c = {1'b0, ys1[FRAC_BITS-1:0]};
    end else begin
      part_y_c = PART_W'(ONE_FIX);
    end

    div_req.start = 1'b0;
    div_req.num   = y2 - y1;
    div_req.den   = mag32(x2 - x1);
    if (state == ST_SETUP) begin
      div_req.start = xup_c | xdn_c;
    end else if (state == ST_ADDY) begin
      div_req.start = yup | ydn;
      div_req.num   = x2 - x1;
      div_req.den   = mag32(y2 - y1);
    end

    if (state == ST_MULX) begin
      mul_a = part_y;
      mul_b = xslope;
    end else begin
      mul_a = part_x;
      mul_b = yslope;
    end
    mul_p = (PART_W+WORD_W)'($signed({1'b0, mul_a}) * $signed(mul_b));

    row_w     = {{(WORD_W-COL_W){row[COL_W-1]}}, row};
    col_w     = {{(WORD_W-COL_W){col[COL_W-1]}}, col};
    ycell     = {{FRAC_BITS{ycross[WORD_W-1]}}, ycross[WORD_W-1:FRAC_BITS]};
    xcell     = {{FRAC_BITS{xcross[WORD_W-1]}}, xcross[WORD_W-1:FRAC_BITS]};
    hit       = (col == {{(COL_W-CI_W){cx2[CI_W-1]}}, cx2})
              && (row == {{(COL_W-CI_W){cy2[CI_W-1]}}, cy2});
    at_limit  = (cnt == CNT_W'(MAX_CELLS - 1));
    emit      = (state == ST_WALK) && (!m_tvalid || m_tready);
    emit_last = hit || at_limit;
  end

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && !emit) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x1    <= s_tdata[WORD_W-1:0] - origin_x;
            y1    <= s_tdata[2*WORD_W-1:WORD_W] - origin_y;
            x2    <= s_tdata[3*WORD_W-1:2*WORD_W] - origin_x;
            y2    <= s_tdata[4*WORD_W-1:3*WORD_W] - origin_y;
            state <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          if (x1[CELL_SHIFT-1:0] == '0) begin
            x1 <= x1 + ONE_FIX;
          end
          if (y1[CELL_SHIFT-1:0] == '0) begin
            y1 <= y1 + ONE_FIX;
          end
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          cx2    <= cx2_c;
          cy2    <= cy2_c;
          col    <= {{(COL_W-CI_W){cx1_c[CI_W-1]}}, cx1_c};
          row    <= {{(COL_W-CI_W){cy1_c[CI_W-1]}}, cy1_c};
          xup    <= xup_c;
          xdn    <= xdn_c;
          yup    <= yup_c;
          ydn    <= ydn_c;
          part_x <= part_x_c;
          part_y <= part_y_c;
          cnt    <= '0;
          state  <= ST_WAITY;
        end
        ST_WAITY: begin
          if (!(xup || xdn)) begin
            yslope <= FLAT_SLOPE;
            state  <= ST_MULY;
          end else if (div_rsp.done) begin
            yslope <= div_rsp.quot;
            state  <= ST_MULY;
          end
        end
        ST_MULY: begin
          prod  <= mul_p[FRAC_BITS+WORD_W-1:FRAC_BITS];
          state <= ST_ADDY;
        end
        ST_ADDY: begin
          ycross <= ys1 + prod;
          state  <= ST_WAITX;
        end
        ST_WAITX: begin
          if (!(yup || ydn)) begin
            xslope <= FLAT_SLOPE;
            state  <= ST_MULX;
          end else if (div_rsp.done) begin
            xslope <= div_rsp.quot;
            state  <= ST_MULX;
          end
        end
        ST_MULX: begin
          prod  <= mul_p[FRAC_BITS+WORD_W-1:FRAC_BITS];
          state <= ST_ADDX;
        end
        ST_ADDX: begin
          xcross <= xs1 + prod;
          state  <= ST_WALK;
        end
        ST_WALK: begin
          if (emit) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {(OUT_TDATA_W-2*CELL_OUT_W)'(0),
                         row[CELL_OUT_W-1:0], col[CELL_OUT_W-1:0]};
            m_tlast  <= emit_last;
            m_tuser  <= hit;
            cnt      <= cnt + 1'b1;
            if (emit_last) begin
              state <= ST_IDLE;
            end else if (ycell == row_w) begin
              ycross <= ycross + yslope;
              if (xup) begin
                col <= col + 1'b1;
              end else if (xdn) begin
                col <= col - 1'b1;
              end
            end else if (xcell == col_w) begin
              xcross <= xcross + xslope;
              if (yup) begin
                row <= row + 1'b1;
              end else if (ydn) begin
                row <= row - 1'b1;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the grid line block walker: segment stream in, cell stream out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import glbw_pkg::*;

  localparam logic [WORD_W-1:0] CELL_LOW_MASK = (WORD_W'(1) << CELL_SHIFT) - 1;
  localparam logic [WORD_W-1:0] FRAC_LOW_MASK = ONE_FIX - 1;

  typedef struct packed {
    logic [CELL_OUT_W-1:0] cell_x;
    logic [CELL_OUT_W-1:0] cell_y;
    logic                  last;
    logic                  reached_end;
  } cell_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  logic [WORD_W-1:0] org_x = '0;
  logic [WORD_W-1:0] org_y = '0;
  cell_t             expected_cells[$];
  bit                idle_on = 1'b1;
  int                mismatches = 0;
  int                segments_sent = 0;
  int                cells_checked = 0;
  int                origins_used = 1;

  grid_line_block_walker dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("Run exceeded its time limit.");
    $display("Mismatches found");
    $finish;
  end

  function automatic int sra(input logic [WORD_W-1:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (WORD_W'(0) - v) : v;
  endfunction

  function automatic logic [WORD_W-1:0] sat_div(input logic [WORD_W-1:0] a, b);
    int     sa, sb;
    longint num, den;
    if ((magnitude(a) >> SAT_SHIFT) >= magnitude(b))
      return ((a ^ b) & SAT_NEG) ? SAT_NEG : SAT_POS;
    sa = a;
    sb = b;
    num = sa;
    num = num * 65536;
    den = sb;
    return WORD_W'(num / den);
  endfunction

  function automatic logic [WORD_W-1:0] mul_fix(input logic [WORD_W-1:0] a, b);
    int     sa, sb;
    longint p;
    sa = a;
    sb = b;
    p = sa;
    p = p * sb;
    return WORD_W'(p >>> FRAC_BITS);
  endfunction

  function automatic void predict_cells(input logic [WORD_W-1:0] sx, sy, ex, ey);
    logic [WORD_W-1:0] x1, y1, x2, y2, part, xslope, yslope, xcross, ycross;
    int                cx1, cy1, cx2, cy2, colstep, rowstep, col, row;
    cell_t             c;
    x1 = sx;
    y1 = sy;
    if (((x1 - org_x) & CELL_LOW_MASK) == 0) x1 += ONE_FIX;
    if (((y1 - org_y) & CELL_LOW_MASK) == 0) y1 += ONE_FIX;
    x1 -= org_x;
    y1 -= org_y;
    x2 = ex - org_x;
    y2 = ey - org_y;
    cx1 = sra(x1, CELL_SHIFT);
    cy1 = sra(y1, CELL_SHIFT);
    cx2 = sra(x2, CELL_SHIFT);
    cy2 = sra(y2, CELL_SHIFT);

    if (cx2 > cx1) begin
      colstep = 1;
      part = ONE_FIX - (WORD_W'(sra(x1, SUB_SHIFT)) & FRAC_LOW_MASK);
      yslope = sat_div(y2 - y1, magnitude(x2 - x1));
    end else if (cx2 < cx1) begin
      colstep = -1;
      part = WORD_W'(sra(x1, SUB_SHIFT)) & FRAC_LOW_MASK;
      yslope = sat_div(y2 - y1, magnitude(x2 - x1));
    end else begin
      colstep = 0;
      part = ONE_FIX;
      yslope = FLAT_SLOPE;
    end
    ycross = WORD_W'(sra(y1, SUB_SHIFT)) + mul_fix(part, yslope);

    if (cy2 > cy1) begin
      rowstep = 1;
      part = ONE_FIX - (WORD_W'(sra(y1, SUB_SHIFT)) & FRAC_LOW_MASK);
      xslope = sat_div(x2 - x1, magnitude(y2 - y1));
    end else if (cy2 < cy1) begin
      rowstep = -1;
      part = WORD_W'(sra(y1, SUB_SHIFT)) & FRAC_LOW_MASK;
      xslope = sat_div(x2 - x1, magnitude(y2 - y1));
    end else begin
      rowstep = 0;
      part = ONE_FIX;
      xslope = FLAT_SLOPE;
    end
    xcross = WORD_W'(sra(x1, SUB_SHIFT)) + mul_fix(part, xslope);

    col = cx1;
    row = cy1;
    for (int n = 0; n < MAX_CELLS; n++) begin
      c.cell_x = CELL_OUT_W'(col);
      c.cell_y = CELL_OUT_W'(row);
      c.last = 1'b0;
      c.reached_end = 1'b0;
      if (col == cx2 && row == cy2) begin
        c.last = 1'b1;
        c.reached_end = 1'b1;
        expected_cells.push_back(c);
        return;
      end
      if (sra(ycross, FRAC_BITS) == row) begin
        ycross += yslope;
        col += colstep;
      end else if (sra(xcross, FRAC_BITS) == col) begin
        xcross += xslope;
        row += rowstep;
      end
      if (n == MAX_CELLS - 1) c.last = 1'b1;
      expected_cells.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t: cell check failed: %s", $realtime, what);
  endtask

  task automatic send_segment(input logic [WORD_W-1:0] sx, sy, ex, ey);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {ey, ex, sy, sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_cells(sx, sy, ex, ey);
    segments_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_cells.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_origin(input logic [WORD_W-1:0] ox, oy);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_data <= oy;
    @(posedge clk);
    cfg_we <= 1'b0;
    org_x = ox;
    org_y = oy;
    origins_used++;
  endtask

  initial begin : cell_receiver
    int    stall_left;
    cell_t want;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        cells_checked++;
        if (expected_cells.size() == 0) begin
          report_mismatch("cell transaction with nothing expected");
        end else begin
          want = expected_cells.pop_front();
          if (m_tdata[CELL_OUT_W-1:0] !== want.cell_x)
            report_mismatch($sformatf("cell_x got %0d want %0d",
                            $signed(m_tdata[CELL_OUT_W-1:0]), $signed(want.cell_x)));
          if (m_tdata[2*CELL_OUT_W-1:CELL_OUT_W] !== want.cell_y)
            report_mismatch($sformatf("cell_y got %0d want %0d",
                            $signed(m_tdata[2*CELL_OUT_W-1:CELL_OUT_W]), $signed(want.cell_y)));
          if (m_tdata[OUT_TDATA_W-1:2*CELL_OUT_W] !== '0)
            report_mismatch($sformatf("fill bits got %h", m_tdata[OUT_TDATA_W-1:2*CELL_OUT_W]));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("last got %b want %b", m_tlast, want.last));
          if (m_tuser !== want.reached_end)
            report_mismatch($sformatf("reached_end got %b want %b", m_tuser, want.reached_end));
        end
        stall_left = idle_on ? $urandom_range(0, 19) : 0;
        if (stall_left > 0) m_tready <= 1'b0;
      end else if (!m_tready) begin
        if (stall_left <= 1) m_tready <= 1'b1;
        stall_left--;
      end
    end
  end

  task automatic test_directed();
    send_segment(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_segment(32'h0012_3456, 32'h0034_5678, 32'h0012_3456, 32'h0034_5678);
    send_segment(32'h0040_0000, 32'h0040_0000, 32'h0050_0000, 32'h0A40_0000);
    send_segment(32'h0040_0000, 32'h0040_0000, 32'hF600_0000, 32'h0050_0000);
    send_segment(32'h0012_3456, 32'h0065_4321, 32'h0543_2100, 32'h0432_1000);
    send_segment(32'h0543_2100, 32'h0432_1000, 32'h0012_3456, 32'h0065_4321);
    send_segment(32'h0080_0000, 32'h0012_3456, 32'h0200_0000, 32'h0100_0000);
    send_segment(32'h0030_0000, 32'hFF80_0000, 32'hFE00_0000, 32'hFD00_0000);
    send_segment(32'h007F_FFF0, 32'h0010_0000, 32'h0080_0010, 32'h0400_0000);
    send_segment(32'h0080_0010, 32'h0400_0000, 32'h007F_FFF0, 32'h0010_0000);
    send_segment(32'h007F_FFF0, 32'h0400_0000, 32'h0080_0010, 32'hFC00_0000);
    send_segment(32'h0000_0001, 32'h0040_0000, 32'h8000_0001, 32'h0040_0000);
    send_segment(32'h0040_0000, 32'h0000_0001, 32'h0040_0000, 32'h8000_0001);
    send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_segment(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    wait_idle();
  endtask

  task automatic test_origin_settings();
    logic [WORD_W-1:0] ox_list[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                      32'h1234_5678, 32'h0000_0000};
    logic [WORD_W-1:0] oy_list[5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                      32'hFEDC_BA98, 32'h0000_0000};
    for (int i = 0; i < 5; i++) begin
      set_origin(ox_list[i], oy_list[i]);
      send_segment(org_x, org_y, org_x + 32'h0180_0000, org_y - 32'h0100_0000);
      send_segment(org_x + 32'h0023_4567, org_y - 32'h0276_5432,
                   org_x - 32'h0345_6789, org_y + 32'h0012_3456);
      send_segment(org_x + 32'h0023_4567, org_y + 32'h0001_0000,
                   org_x + 32'h0023_4567, org_y + 32'h0001_0000);
    end
    wait_idle();
  endtask

  task automatic test_random_walks();
    logic [WORD_W-1:0] sx, sy, ex, ey, ssx, ssy, esx, esy, tmp;
    int                scx, scy, ecx, ecy, kind, t;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1:       set_origin(SAT_POS, SAT_NEG);
        2:       set_origin(SAT_NEG, SAT_POS);
        default: set_origin($urandom, $urandom);
      endcase
      idle_on = (phase != 3);
      for (int i = 0; i < 68; i++) begin
        if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
        if ($urandom_range(0, 39) == 0) wait_idle();
        kind = $urandom_range(0, 19);
        scx = int'($urandom_range(0, 80)) - 40;
        scy = int'($urandom_range(0, 80)) - 40;
        ecx = scx + int'($urandom_range(0, 40)) - 20;
        ecy = scy + int'($urandom_range(0, 40)) - 20;
        ssx = $urandom & CELL_LOW_MASK;
        ssy = $urandom & CELL_LOW_MASK;
        esx = $urandom & CELL_LOW_MASK;
        esy = $urandom & CELL_LOW_MASK;
        case (kind)
          10, 11: begin
            if ($urandom_range(0, 2) != 1) ssx = '0;
            if ($urandom_range(0, 2) != 0) ssy = '0;
          end
          12: ecx = scx;
          13: ecy = scy;
          14, 15: begin
            ssx = CELL_LOW_MASK - $urandom_range(0, 255);
            esx = $urandom_range(0, 255);
            ecx = scx + 1;
            if ($urandom_range(0, 1)) begin
              t = scx; scx = ecx; ecx = t;
              tmp = ssx; ssx = esx; esx = tmp;
            end
          end
          16, 17: begin
            ecx = scx + int'($urandom_range(0, 400)) - 200;
            ecy = scy + int'($urandom_range(0, 400)) - 200;
          end
          default: ;
        endcase
        sx = org_x + WORD_W'(scx <<< CELL_SHIFT) + ssx;
        sy = org_y + WORD_W'(scy <<< CELL_SHIFT) + ssy;
        ex = org_x + WORD_W'(ecx <<< CELL_SHIFT) + esx;
        ey = org_y + WORD_W'(ecy <<< CELL_SHIFT) + esy;
        if (kind >= 18) begin
          sx = $urandom;
          sy = $urandom;
          ex = $urandom;
          ey = $urandom;
        end
        send_segment(sx, sy, ex, ey);
      end
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_origin_settings();
    test_random_walks();
    wait_idle();
    repeat (100) @(posedge clk);
    $display("Walked %0d segments into %0d checked cell transactions under %0d origin settings,",
             segments_sent, cells_checked, origins_used);
    $display("including edge starts, flat and saturated slopes, wrapped cells and cell limits.");
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
